// ===== sv/tcp_passive_segment_responder_core_macros.svh =====
// Assertion helper used by the RTL controller (tpsr_ctrl).
`ifndef TCP_PASSIVE_SEGMENT_RESPONDER_CORE_MACROS_SVH
`define TCP_PASSIVE_SEGMENT_RESPONDER_CORE_MACROS_SVH

// Clocked assertion, disabled while reset is low.
`define TPSR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tpsr assertion failed");

`endif

// ===== sv/tpsr_pkg.sv =====
`default_nettype none
package tpsr_pkg;

    localparam int CONN_SLOTS = 16;
    localparam int SLOT_W     = (CONN_SLOTS > 1) ? $clog2(CONN_SLOTS) : 1;

    localparam logic [4:0] FLAG_SYN = 5'd1;
    localparam logic [4:0] FLAG_ACK = 5'd2;
    localparam logic [4:0] FLAG_RST = 5'd4;
    localparam logic [4:0] FLAG_PSH = 5'd8;
    localparam logic [4:0] FLAG_FIN = 5'd16;

    localparam logic [1:0] PH_SYN_RCVD    = 2'd0;
    localparam logic [1:0] PH_ESTABLISHED = 2'd1;
    localparam logic [1:0] PH_CLOSE_WAIT  = 2'd2;

    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_RST    = 3'd1;
    localparam logic [2:0] KIND_SYNACK = 3'd2;
    localparam logic [2:0] KIND_ACK    = 3'd3;
    localparam logic [2:0] KIND_ECHO   = 3'd4;
    localparam logic [2:0] KIND_HTTP   = 3'd5;

    localparam logic [15:0] HDR_BYTES  = 16'd20;
    localparam logic [15:0] HTTP_BYTES = 16'd76;

    localparam logic [15:0] ECHO_PORT_RST = 16'd7;
    localparam logic [15:0] WEB_PORT_RST  = 16'd80;

    localparam logic [2:0] REG_ECHO_PORT = 3'd0;
    localparam logic [2:0] REG_WEB_PORT  = 3'd4;

    typedef struct packed {
        logic [31:0] own_ip;
        logic [15:0] own_port;
        logic [31:0] peer_ip;
        logic [15:0] peer_port;
        logic [31:0] seg_seq;
        logic [31:0] seg_ack;
        logic [15:0] seg_window;
        logic [3:0]  header_words;
        logic [15:0] segment_length;
        logic [4:0]  seg_flags;
        logic        options_bad;
        logic [31:0] initial_seq;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]  reply_kind;
        logic [15:0] reply_src_port;
        logic [15:0] reply_dst_port;
        logic [31:0] reply_seq;
        logic [31:0] reply_ackno;
        logic [15:0] reply_window;
        logic [15:0] payload_length;
        logic [15:0] reply_length;
        logic        table_full;
    } t_out_beat;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic execute;
    } t_cmd;

endpackage
`default_nettype wire

// ===== sv/tpsr_ctrl.sv =====
`default_nettype none
`include "tcp_passive_segment_responder_core_macros.svh"
module tpsr_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output tpsr_pkg::t_cmd      o_cmd
);

    typedef enum logic [1:0] {S_IDLE, S_LOOK, S_EXEC, S_OUT} t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // Step one beat through capture, lookup, execute and delivery
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_LOOK;
            end
            S_LOOK: n_state = S_EXEC;
            S_EXEC: begin
                n_state     = S_OUT;
                n_out_valid = 1'b1;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b0;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_cmd.capture = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.lookup  = (r_state == S_LOOK);
    assign o_cmd.execute = (r_state == S_EXEC);

    `TPSR_ASSERT(a_accept_to_look, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> (r_state == S_LOOK))
    `TPSR_ASSERT(a_no_ready_with_result, i_clk, i_rst_n, o_out_valid |-> !o_in_ready)
    `TPSR_ASSERT(a_exec_gives_result, i_clk, i_rst_n, o_cmd.execute |=> o_out_valid)

endmodule
`default_nettype wire

// ===== sv/tpsr_datapath.sv =====
`default_nettype none
module tpsr_datapath (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire tpsr_pkg::t_cmd       i_cmd,
    input  wire tpsr_pkg::t_in_beat   i_in_beat,
    input  wire logic [15:0]          i_echo_port,
    input  wire logic [15:0]          i_web_port,
    output tpsr_pkg::t_out_beat       o_out_beat
);

    localparam int N = tpsr_pkg::CONN_SLOTS;
    localparam int W = tpsr_pkg::SLOT_W;

    // Connection table
    logic        r_used      [N];
    logic [31:0] r_own_ip    [N];
    logic [15:0] r_own_port  [N];
    logic [31:0] r_peer_ip   [N];
    logic [15:0] r_peer_port [N];
    logic [1:0]  r_phase     [N];
    logic [31:0] r_own_seq   [N];
    logic [31:0] r_peer_seq  [N];
    logic [15:0] r_peer_win  [N];

    tpsr_pkg::t_in_beat  r_in;
    tpsr_pkg::t_out_beat r_out, n_out;
    logic         r_hit, n_hit, r_free, n_free;
    logic [W-1:0] r_hit_idx, n_hit_idx, r_free_idx, n_free_idx;
    logic [15:0]  r_dlen, n_dlen;
    logic [17:0]  hbytes;

    // Parallel tuple match; lowest match and lowest free slot win
    always_comb begin
        n_hit      = 1'b0;
        n_free     = 1'b0;
        n_hit_idx  = '0;
        n_free_idx = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (r_used[i]) begin
                if (r_own_ip[i] == r_in.own_ip && r_own_port[i] == r_in.own_port &&
                    r_peer_ip[i] == r_in.peer_ip && r_peer_port[i] == r_in.peer_port) begin
                    n_hit     = 1'b1;
                    n_hit_idx = W'(i);
                end
            end else begin
                n_free     = 1'b1;
                n_free_idx = W'(i);
            end
        end
        hbytes = {12'd0, r_in.header_words, 2'b00};
        n_dlen = ({2'b00, r_in.segment_length} > hbytes)
               ? 16'(({2'b00, r_in.segment_length}) - hbytes) : 16'd0;
    end

    // Decide reply and table update for the matched entry
    logic [1:0]  ent_ph, new_ph;
    logic [31:0] ent_seq, seq_p1, seq_dlen;
    logic [15:0] ent_win, pay;
    logic        wr_new, wr_upd, clr_used;
    logic [1:0]  upd_ph;
    logic [31:0] upd_own_seq, upd_peer_seq;
    logic [2:0]  kind;

    always_comb begin
        ent_ph       = r_phase[r_hit_idx];
        ent_seq      = r_own_seq[r_hit_idx];
        ent_win      = r_peer_win[r_hit_idx];
        seq_p1       = r_in.seg_seq + 32'd1;
        seq_dlen     = r_in.seg_seq + {16'd0, r_dlen};
        new_ph       = (ent_ph == tpsr_pkg::PH_SYN_RCVD && r_in.seg_ack == ent_seq + 32'd1)
                     ? tpsr_pkg::PH_ESTABLISHED : ent_ph;
        wr_new       = 1'b0;
        wr_upd       = 1'b0;
        clr_used     = 1'b0;
        upd_ph       = new_ph;
        upd_own_seq  = ent_seq;
        upd_peer_seq = r_in.seg_seq;
        pay          = 16'd0;
        kind         = tpsr_pkg::KIND_NONE;
        n_out        = '0;

        if (r_in.options_bad) begin
            kind = tpsr_pkg::KIND_NONE;
        end else if ((r_in.seg_flags & tpsr_pkg::FLAG_SYN) != 5'd0) begin
            if (r_hit) begin
                kind = tpsr_pkg::KIND_RST;
            end else begin
                kind   = tpsr_pkg::KIND_SYNACK;
                wr_new = r_free;
                n_out.table_full     = !r_free;
                n_out.reply_seq      = r_in.initial_seq;
                n_out.reply_ackno    = seq_p1;
                n_out.reply_window   = r_in.seg_window;
            end
        end else if ((r_in.seg_flags & tpsr_pkg::FLAG_ACK) != 5'd0) begin
            if (!r_hit) begin
                kind = tpsr_pkg::KIND_RST;
            end else begin
                wr_upd = 1'b1;
                if (new_ph == tpsr_pkg::PH_ESTABLISHED &&
                    (r_in.seg_flags & tpsr_pkg::FLAG_PSH) != 5'd0) begin
                    upd_own_seq  = r_in.seg_ack;
                    upd_peer_seq = seq_dlen;
                    if (r_in.own_port == i_echo_port) begin
                        kind = tpsr_pkg::KIND_ECHO;
                        pay  = r_dlen;
                    end else if (r_in.own_port == i_web_port) begin
                        kind = tpsr_pkg::KIND_HTTP;
                        pay  = tpsr_pkg::HTTP_BYTES;
                    end else begin
                        kind = tpsr_pkg::KIND_ACK;
                    end
                end else if (new_ph == tpsr_pkg::PH_ESTABLISHED &&
                             (r_in.seg_flags & tpsr_pkg::FLAG_FIN) != 5'd0) begin
                    upd_own_seq  = r_in.seg_ack;
                    upd_peer_seq = seq_p1;
                    upd_ph       = tpsr_pkg::PH_CLOSE_WAIT;
                    kind         = tpsr_pkg::KIND_ACK;
                end else if (new_ph == tpsr_pkg::PH_CLOSE_WAIT) begin
                    clr_used = 1'b1;
                end
                n_out.reply_seq    = upd_own_seq;
                n_out.reply_ackno  = upd_peer_seq;
                n_out.reply_window = ent_win;
            end
        end else if ((r_in.seg_flags & (tpsr_pkg::FLAG_RST | tpsr_pkg::FLAG_FIN)) != 5'd0
                     && r_hit) begin
            clr_used = (r_in.seg_flags & tpsr_pkg::FLAG_RST) != 5'd0;
        end else begin
            kind = tpsr_pkg::KIND_RST;
        end

        // RST-ACK carries only ports and seq+1
        if (kind == tpsr_pkg::KIND_RST) begin
            n_out.reply_seq    = 32'd0;
            n_out.reply_ackno  = seq_p1;
            n_out.reply_window = 16'd0;
        end
        if (kind == tpsr_pkg::KIND_NONE) begin
            n_out = '0;
        end else begin
            n_out.reply_kind     = kind;
            n_out.reply_src_port = r_in.own_port;
            n_out.reply_dst_port = r_in.peer_port;
            n_out.payload_length = pay;
            n_out.reply_length   = tpsr_pkg::HDR_BYTES + pay;
        end
    end

    // Capture beat, register lookup, register result
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) r_in <= i_in_beat;
        if (i_cmd.lookup) begin
            r_hit      <= n_hit;
            r_hit_idx  <= n_hit_idx;
            r_free     <= n_free;
            r_free_idx <= n_free_idx;
            r_dlen     <= n_dlen;
        end
        if (i_cmd.execute) r_out <= n_out;
    end

    // Table payload writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute && wr_new) begin
            r_own_ip[r_free_idx]    <= r_in.own_ip;
            r_own_port[r_free_idx]  <= r_in.own_port;
            r_peer_ip[r_free_idx]   <= r_in.peer_ip;
            r_peer_port[r_free_idx] <= r_in.peer_port;
            r_phase[r_free_idx]     <= tpsr_pkg::PH_SYN_RCVD;
            r_own_seq[r_free_idx]   <= r_in.initial_seq;
            r_peer_seq[r_free_idx]  <= seq_p1;
            r_peer_win[r_free_idx]  <= r_in.seg_window;
        end else if (i_cmd.execute && wr_upd) begin
            r_phase[r_hit_idx]    <= upd_ph;
            r_own_seq[r_hit_idx]  <= upd_own_seq;
            r_peer_seq[r_hit_idx] <= upd_peer_seq;
        end
    end

    // Slot valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++) r_used[i] <= 1'b0;
        end else if (i_cmd.execute) begin
            if (wr_new) r_used[r_free_idx] <= 1'b1;
            else if (clr_used) r_used[r_hit_idx] <= 1'b0;
        end
    end

    assign o_out_beat = r_out;

endmodule
`default_nettype wire

// ===== sv/tcp_passive_segment_responder_core.sv =====
// Channel   | Handshake                   | Payload
// ----------+-----------------------------+------------------------
// segment   | i_in_valid / o_in_ready     | i_in_beat  (t_in_beat)
// reply     | o_out_valid / i_out_ready   | o_out_beat (t_out_beat)
// config    | psel/penable/pwrite, pready | paddr, pwdata, prdata
//
// Each segment steps through capture, table lookup, and decide and update,
// then its reply is held for delivery; the next segment waits until it leaves.
// The controller sequences these steps around the single table update.
// Reset is synchronous, active low; it clears all slots and loads ports 7/80.
// A stalled reply holds the block; no new segment is taken until it leaves.
`default_nettype none
module tcp_passive_segment_responder_core (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire tpsr_pkg::t_in_beat   i_in_beat,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output tpsr_pkg::t_out_beat       o_out_beat,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    tpsr_pkg::t_cmd cmd;
    logic [15:0]    r_echo_port, r_web_port;
    logic           wr_en;

    // Register writes on the access phase
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo_port <= tpsr_pkg::ECHO_PORT_RST;
            r_web_port  <= tpsr_pkg::WEB_PORT_RST;
        end else if (wr_en) begin
            unique case (paddr)
                tpsr_pkg::REG_ECHO_PORT: r_echo_port <= pwdata[15:0];
                tpsr_pkg::REG_WEB_PORT:  r_web_port  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (paddr)
            tpsr_pkg::REG_ECHO_PORT: prdata = {16'd0, r_echo_port};
            tpsr_pkg::REG_WEB_PORT:  prdata = {16'd0, r_web_port};
            default:                 prdata = 32'd0;
        endcase
    end

    tpsr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    tpsr_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_beat   (i_in_beat),
        .i_echo_port (r_echo_port),
        .i_web_port  (r_web_port),
        .o_out_beat  (o_out_beat)
    );

endmodule
`default_nettype wire
